### hdl/bez_pkg.sv
package bez_pkg;

  // field and datapath widths
  localparam int unsigned COORD_W   = 24;
  localparam int unsigned SEG_W     = 6;
  localparam int unsigned WGT_W     = 12;
  localparam int unsigned ACC_W     = 37;
  localparam int unsigned MAG_W     = 36;
  localparam int unsigned DEN_W     = 12;
  localparam int unsigned DIV_STEPS = COORD_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  // blend term selects
  localparam logic [1:0] TERM_START = 2'd0;
  localparam logic [1:0] TERM_CTRL  = 2'd1;
  localparam logic [1:0] TERM_END   = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WGT,
    ST_MAC,
    ST_DIVGO,
    ST_DIV,
    ST_EMIT
  } state_e;

  // control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic en;
    logic clr;
  } mac_ctl_t;

endpackage

### hdl/bez_mac.sv
module bez_mac (
  input  logic                                   clk_i,
  input  bez_pkg::mac_ctl_t                      ctl_i,
  input  logic signed [bez_pkg::COORD_W-1:0]     coord_i,
  input  logic        [bez_pkg::WGT_W-1:0]       weight_i,
  output logic signed [bez_pkg::ACC_W-1:0]       acc_o
);

  logic signed [bez_pkg::ACC_W-1:0] acc_q, acc_d;
  logic signed [bez_pkg::ACC_W-1:0] prod;

  // weight is unsigned, so extend it with a zero sign bit
  assign prod = coord_i * $signed({1'b0, weight_i});

  // clear on the first term of a sum, accumulate otherwise
  always_comb begin
    acc_d = acc_q;
    if (ctl_i.en) begin
      acc_d = (ctl_i.clr ? '0 : acc_q) + prod;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

### hdl/bez_div.sv
module bez_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [bez_pkg::ACC_W-1:0]    num_i,
  input  logic        [bez_pkg::DEN_W-1:0]    den_i,
  output logic                                busy_o,
  output logic                                done_o,
  output logic signed [bez_pkg::COORD_W-1:0]  quo_o
);

  logic                               neg;
  logic        [bez_pkg::ACC_W-1:0]   mag_full;
  logic        [bez_pkg::MAG_W-1:0]   dividend;
  logic                               ge;

  logic                               busy_q, busy_d;
  logic                               done_q, done_d;
  logic        [bez_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic        [bez_pkg::MAG_W-1:0]   rem_q, rem_d;
  logic        [bez_pkg::MAG_W-1:0]   dsh_q, dsh_d;
  logic        [bez_pkg::COORD_W-1:0] quo_q, quo_d;
  logic                               neg_q, neg_d;

  // magnitude plus half the divisor, ties round away from zero
  assign neg      = num_i[bez_pkg::ACC_W-1];
  assign mag_full = neg ? 37'(-num_i) : 37'(num_i);
  assign dividend = mag_full[bez_pkg::MAG_W-1:0]
                  + bez_pkg::MAG_W'(den_i >> 1);

  assign ge = (rem_q >= dsh_q);

  // one quotient bit per cycle, msb first
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = bez_pkg::CNT_W'(bez_pkg::DIV_STEPS - 1);
      rem_d  = dividend;
      dsh_d  = bez_pkg::MAG_W'(den_i) << (bez_pkg::DIV_STEPS - 1);
      quo_d  = '0;
      neg_d  = neg;
    end else if (busy_q) begin
      rem_d = ge ? (rem_q - dsh_q) : rem_q;
      dsh_d = dsh_q >> 1;
      quo_d = {quo_q[bez_pkg::COORD_W-2:0], ge};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = neg_q ? $signed(-quo_q) : $signed(quo_q);

endmodule

### hdl/quadratic_bezier_point_generator.sv
// channel   signals                                          direction
// request   in_valid_i in_ready_o start/ctrl/end x,y seg_count  in
// point     out_valid_o out_ready_i point_x/y final_point       out
//
// each point takes one weight step, then per coordinate three multiply-accumulate
// steps, one divider launch and a wait on the shared divider for its 24 restoring
// steps, then one emit step, which waits while the output is stalled; a request
// gives seg_count+1 points, with seg_count capped at MAX_SEGMENTS.
// zero segments goes straight from the request to the emit step for the start point.
// reset clears the sequencer and the output valid; no clearing pass.
// a stalled point waits in the output register while the next one is built.
module quadratic_bezier_point_generator #(
  parameter int unsigned MAX_SEGMENTS = 63
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [bez_pkg::COORD_W-1:0]  start_x_i,
  input  logic signed [bez_pkg::COORD_W-1:0]  start_y_i,
  input  logic signed [bez_pkg::COORD_W-1:0]  ctrl_x_i,
  input  logic signed [bez_pkg::COORD_W-1:0]  ctrl_y_i,
  input  logic signed [bez_pkg::COORD_W-1:0]  end_x_i,
  input  logic signed [bez_pkg::COORD_W-1:0]  end_y_i,
  input  logic        [bez_pkg::SEG_W-1:0]    seg_count_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [bez_pkg::COORD_W-1:0]  point_x_o,
  output logic signed [bez_pkg::COORD_W-1:0]  point_y_o,
  output logic                                final_point_o
);

  localparam logic [bez_pkg::SEG_W-1:0] MaxSeg = bez_pkg::SEG_W'(MAX_SEGMENTS);

  bez_pkg::state_e state_q, state_d;

  logic                               in_acc;
  logic                               out_free;
  logic        [bez_pkg::SEG_W-1:0]   seg_sat;

  logic signed [bez_pkg::COORD_W-1:0] x0_q, y0_q, x1_q, y1_q, x2_q, y2_q;
  logic        [bez_pkg::SEG_W-1:0]   s_q;
  logic        [bez_pkg::SEG_W-1:0]   i_q, i_d;
  logic        [bez_pkg::DEN_W-1:0]   den_q;
  logic        [1:0]                  term_q, term_d;
  logic                               ysel_q, ysel_d;
  logic        [bez_pkg::WGT_W-1:0]   w0_q, w1_q, w2_q;
  logic signed [bez_pkg::COORD_W-1:0] xres_q, yres_q;

  logic                               out_valid_q;
  logic signed [bez_pkg::COORD_W-1:0] point_x_q, point_y_q;
  logic                               final_q;

  // sequencer outputs
  bez_pkg::mac_ctl_t                  mac_ctl;
  logic                               div_start;
  logic                               wgt_load;
  logic                               emit_load;
  logic                               is_last;

  logic        [bez_pkg::SEG_W-1:0]   r_val;
  logic signed [bez_pkg::COORD_W-1:0] mac_coord;
  logic        [bez_pkg::WGT_W-1:0]   mac_weight;
  logic signed [bez_pkg::ACC_W-1:0]   acc;
  logic                               div_busy;
  logic                               div_done;
  logic signed [bez_pkg::COORD_W-1:0] quo;

  assign in_acc   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign seg_sat  = (seg_count_i > MaxSeg) ? MaxSeg : seg_count_i;
  assign is_last  = (i_q == s_q);
  assign r_val    = s_q - i_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bez_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (seg_sat == '0) ? bez_pkg::ST_EMIT : bez_pkg::ST_WGT;
        end
      end
      bez_pkg::ST_WGT:   state_d = bez_pkg::ST_MAC;
      bez_pkg::ST_MAC: begin
        if (term_q == bez_pkg::TERM_END) begin
          state_d = bez_pkg::ST_DIVGO;
        end
      end
      bez_pkg::ST_DIVGO: state_d = bez_pkg::ST_DIV;
      bez_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = ysel_q ? bez_pkg::ST_EMIT : bez_pkg::ST_MAC;
        end
      end
      bez_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = is_last ? bez_pkg::ST_IDLE : bez_pkg::ST_WGT;
        end
      end
      default: state_d = bez_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o  = 1'b0;
    mac_ctl.en  = 1'b0;
    mac_ctl.clr = 1'b0;
    div_start   = 1'b0;
    wgt_load    = 1'b0;
    emit_load   = 1'b0;
    case (state_q)
      bez_pkg::ST_IDLE:  in_ready_o = 1'b1;
      bez_pkg::ST_WGT:   wgt_load   = 1'b1;
      bez_pkg::ST_MAC: begin
        mac_ctl.en  = 1'b1;
        mac_ctl.clr = (term_q == bez_pkg::TERM_START);
      end
      bez_pkg::ST_DIVGO: div_start  = 1'b1;
      bez_pkg::ST_DIV:   ;
      bez_pkg::ST_EMIT:  emit_load  = out_free;
      default:           ;
    endcase
  end

  // term, coordinate and point counters
  always_comb begin
    term_d = term_q;
    ysel_d = ysel_q;
    i_d    = i_q;
    if (in_acc) begin
      i_d = '0;
    end
    if (wgt_load) begin
      term_d = bez_pkg::TERM_START;
      ysel_d = 1'b0;
    end
    if (mac_ctl.en) begin
      term_d = (term_q == bez_pkg::TERM_END) ? bez_pkg::TERM_START : term_q + 2'd1;
    end
    if (div_done) begin
      ysel_d = 1'b1;
    end
    if (emit_load && !is_last) begin
      i_d = i_q + 1'b1;
    end
  end

  // operand select for the shared multiply-accumulate unit
  always_comb begin
    case (term_q)
      bez_pkg::TERM_START: begin
        mac_coord  = ysel_q ? y0_q : x0_q;
        mac_weight = w0_q;
      end
      bez_pkg::TERM_CTRL: begin
        mac_coord  = ysel_q ? y1_q : x1_q;
        mac_weight = w1_q;
      end
      bez_pkg::TERM_END: begin
        mac_coord  = ysel_q ? y2_q : x2_q;
        mac_weight = w2_q;
      end
      default: begin
        mac_coord  = '0;
        mac_weight = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bez_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      term_q      <= bez_pkg::TERM_START;
      ysel_q      <= 1'b0;
      i_q         <= '0;
    end else begin
      state_q <= state_d;
      term_q  <= term_d;
      ysel_q  <= ysel_d;
      i_q     <= i_d;
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request, weight, result and output payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x0_q   <= start_x_i;
      y0_q   <= start_y_i;
      x1_q   <= ctrl_x_i;
      y1_q   <= ctrl_y_i;
      x2_q   <= end_x_i;
      y2_q   <= end_y_i;
      s_q    <= seg_sat;
      den_q  <= bez_pkg::DEN_W'(seg_sat) * bez_pkg::DEN_W'(seg_sat);
      xres_q <= start_x_i;
      yres_q <= start_y_i;
    end
    if (wgt_load) begin
      w0_q <= bez_pkg::WGT_W'(r_val) * bez_pkg::WGT_W'(r_val);
      w1_q <= bez_pkg::WGT_W'({r_val, 1'b0}) * bez_pkg::WGT_W'(i_q);
      w2_q <= bez_pkg::WGT_W'(i_q) * bez_pkg::WGT_W'(i_q);
    end
    if (div_done) begin
      if (ysel_q) begin
        yres_q <= quo;
      end else begin
        xres_q <= quo;
      end
    end
    if (emit_load) begin
      point_x_q <= xres_q;
      point_y_q <= yres_q;
      final_q   <= is_last;
    end
  end

  bez_mac u_mac (
    .clk_i    (clk_i),
    .ctl_i    (mac_ctl),
    .coord_i  (mac_coord),
    .weight_i (mac_weight),
    .acc_o    (acc)
  );

  bez_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (acc),
    .den_i   (den_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign out_valid_o   = out_valid_q;
  assign point_x_o     = point_x_q;
  assign point_y_o     = point_y_q;
  assign final_point_o = final_q;

  // the block is busy right after taking a request
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("request taken while previous request still in progress");

  // the divider only runs while the sequencer waits on it
  a_div_in_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> (state_q == bez_pkg::ST_DIV))
    else $error("divider busy outside its wait state");

  // the point index never passes the segment count
  a_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != bez_pkg::ST_IDLE) |-> (i_q <= s_q))
    else $error("point index past segment count");

  // a point is loaded only into a free output register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !emit_load)
    else $error("output overwritten while stalled");

endmodule
